@@ hdl/feb_pkg.sv @@
//------------------------------------------------------------------------------
// feb_pkg
// Shared types and constants of the feathering blend: field widths, the
// pixel and result payloads, the configuration view and the divider feed.
//------------------------------------------------------------------------------
`default_nettype none

package feb_pkg;

	localparam int COL_W      = 11;
	localparam int START_W    = 11;
	localparam int END_W      = 12;
	localparam int PIX_W      = 8;
	localparam int NCH        = 3;
	localparam int MAX_WIDTH  = 2048;

	// p1*(end-col) + p2*(col-start) <= 255 * (end-start) <= 255 * MAX_WIDTH
	localparam int ACC_W      = PIX_W + $clog2(MAX_WIDTH);

	// restoring divider: quotient bits resolved per stage and stage count
	localparam int DIV_BITS   = 2;
	localparam int DIV_STAGES = PIX_W / DIV_BITS;

	localparam logic [START_W-1:0] START_RESET = START_W'(470);
	localparam logic [END_W-1:0]   END_RESET   = END_W'(630);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_START = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_END   = 1'b1;

	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [PIX_W-1:0] first_blue;
		logic [PIX_W-1:0] first_green;
		logic [PIX_W-1:0] first_red;
		logic [PIX_W-1:0] second_blue;
		logic [PIX_W-1:0] second_green;
		logic [PIX_W-1:0] second_red;
	} pixel_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_blue;
		logic [PIX_W-1:0] out_green;
		logic [PIX_W-1:0] out_red;
	} blend_t;

	typedef struct packed {
		logic [START_W-1:0] overlap_start;
		logic [END_W-1:0]   overlap_end;
	} cfg_t;

	// channel order inside the packed arrays: 0 blue, 1 green, 2 red
	typedef struct packed {
		logic [NCH-1:0][ACC_W-1:0] acc;
		logic [END_W-1:0]          divisor;
	} div_in_t;

endpackage

`default_nettype wire

@@ hdl/feb_weight.sv @@
//------------------------------------------------------------------------------
// feb_weight
// Three pipeline stages: pick the region and the two weights, multiply each
// channel by its weight, and sum into the dividend for the divider.
//------------------------------------------------------------------------------
`default_nettype none

module feb_weight (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire feb_pkg::cfg_t    cfg,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire feb_pkg::pixel_t  in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output feb_pkg::div_in_t      out_data
);
	import feb_pkg::*;

	logic             vld_s1, vld_s2, vld_s3;
	logic             rdy_s1, rdy_s2, rdy_s3;

	logic [END_W-1:0] w1_s1, w2_s1, div_s1;
	logic [PIX_W-1:0] p1_s1 [NCH];
	logic [PIX_W-1:0] p2_s1 [NCH];

	logic [ACC_W-1:0] m1_s2 [NCH];
	logic [ACC_W-1:0] m2_s2 [NCH];
	logic [END_W-1:0] div_s2;

	div_in_t          sum_s3;

	logic [END_W-1:0] col_x, start_x, end_x;
	logic [END_W-1:0] w1_nx, w2_nx, div_nx;

	// each stage moves when it is empty or the one after it moves
	assign rdy_s3   = !vld_s3 || out_ready;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// region decode; outside the overlap the weight pair is (1,0) or (0,1)
	// over a divisor of one, so the pixel passes the divider unchanged
	always_comb begin
		col_x   = END_W'(in_data.column);
		start_x = END_W'(cfg.overlap_start);
		if (start_x > END_W'(MAX_WIDTH - 1))
			start_x = END_W'(MAX_WIDTH - 1);
		end_x = cfg.overlap_end;
		if (end_x > END_W'(MAX_WIDTH))
			end_x = END_W'(MAX_WIDTH);
		if (col_x < start_x) begin
			w1_nx  = END_W'(1);
			w2_nx  = '0;
			div_nx = END_W'(1);
		end else if (col_x >= end_x) begin
			w1_nx  = '0;
			w2_nx  = END_W'(1);
			div_nx = END_W'(1);
		end else begin
			w1_nx  = end_x - col_x;
			w2_nx  = col_x - start_x;
			div_nx = end_x - start_x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1)
				vld_s1 <= in_valid;
			if (rdy_s2)
				vld_s2 <= vld_s1;
			if (rdy_s3)
				vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			w1_s1    <= w1_nx;
			w2_s1    <= w2_nx;
			div_s1   <= div_nx;
			p1_s1[0] <= in_data.first_blue;
			p1_s1[1] <= in_data.first_green;
			p1_s1[2] <= in_data.first_red;
			p2_s1[0] <= in_data.second_blue;
			p2_s1[1] <= in_data.second_green;
			p2_s1[2] <= in_data.second_red;
		end
		if (rdy_s2 && vld_s1) begin
			div_s2 <= div_s1;
			for (int ch = 0; ch < NCH; ch++) begin
				m1_s2[ch] <= ACC_W'(p1_s1[ch]) * ACC_W'(w1_s1);
				m2_s2[ch] <= ACC_W'(p2_s1[ch]) * ACC_W'(w2_s1);
			end
		end
		if (rdy_s3 && vld_s2) begin
			sum_s3.divisor <= div_s2;
			for (int ch = 0; ch < NCH; ch++)
				sum_s3.acc[ch] <= m1_s2[ch] + m2_s2[ch];
		end
	end

	assign out_valid = vld_s3;
	assign out_data  = sum_s3;

endmodule

`default_nettype wire

@@ hdl/feb_divider.sv @@
//------------------------------------------------------------------------------
// feb_divider
// Pipelined restoring divider, a few quotient bits per stage, three
// channels side by side over one shared divisor. The last stage is the
// result register.
//------------------------------------------------------------------------------
`default_nettype none

module feb_divider (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire feb_pkg::div_in_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output feb_pkg::blend_t        out_data
);
	import feb_pkg::*;

	localparam int DV_W = ACC_W + 1;
	localparam int LAST = DIV_STAGES - 1;

	logic [DIV_STAGES-1:0] vld_s;
	logic [DIV_STAGES:0]   rdy;
	logic [ACC_W-1:0]      rem_s [DIV_STAGES][NCH];
	logic [PIX_W-1:0]      quo_s [DIV_STAGES][NCH];
	logic [END_W-1:0]      div_s [DIV_STAGES];

	assign rdy[DIV_STAGES] = out_ready;
	assign in_ready        = rdy[0];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic             vld_in;
		logic [END_W-1:0] div_in;
		logic [ACC_W-1:0] rem_in [NCH];
		logic [PIX_W-1:0] quo_in [NCH];
		logic [ACC_W-1:0] rem_nx [NCH];
		logic [PIX_W-1:0] quo_nx [NCH];

		if (k == 0) begin : g_head
			always_comb begin
				vld_in = in_valid;
				div_in = in_data.divisor;
				for (int ch = 0; ch < NCH; ch++) begin
					rem_in[ch] = in_data.acc[ch];
					quo_in[ch] = '0;
				end
			end
		end else begin : g_body
			always_comb begin
				vld_in = vld_s[k-1];
				div_in = div_s[k-1];
				for (int ch = 0; ch < NCH; ch++) begin
					rem_in[ch] = rem_s[k-1][ch];
					quo_in[ch] = quo_s[k-1][ch];
				end
			end
		end

		// trial-subtract the shifted divisor, shift the quotient bit in
		always_comb begin
			logic [ACC_W-1:0] r;
			logic [PIX_W-1:0] q;
			logic [DV_W-1:0]  dv;
			r  = '0;
			q  = '0;
			dv = '0;
			for (int ch = 0; ch < NCH; ch++) begin
				r = rem_in[ch];
				q = quo_in[ch];
				for (int j = 0; j < DIV_BITS; j++) begin
					dv = DV_W'(div_in) << (PIX_W - 1 - (k * DIV_BITS + j));
					if ({1'b0, r} >= dv) begin
						r = r - dv[ACC_W-1:0];
						q = {q[PIX_W-2:0], 1'b1};
					end else begin
						q = {q[PIX_W-2:0], 1'b0};
					end
				end
				rem_nx[ch] = r;
				quo_nx[ch] = q;
			end
		end

		assign rdy[k] = !vld_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (rdy[k])
				vld_s[k] <= vld_in;
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && vld_in) begin
				div_s[k] <= div_in;
				for (int ch = 0; ch < NCH; ch++) begin
					rem_s[k][ch] <= rem_nx[ch];
					quo_s[k][ch] <= quo_nx[ch];
				end
			end
		end
	end

	// the dividend stays below 256 times the divisor, so eight quotient
	// bits always hold the full result and no clamp is needed
	assign out_valid         = vld_s[LAST];
	assign out_data.out_blue  = quo_s[LAST][0];
	assign out_data.out_green = quo_s[LAST][1];
	assign out_data.out_red   = quo_s[LAST][2];

	// a finished division leaves a remainder below the divisor
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[LAST] |-> (rem_s[LAST][0] < ACC_W'(div_s[LAST]))
			&& (rem_s[LAST][1] < ACC_W'(div_s[LAST]))
			&& (rem_s[LAST][2] < ACC_W'(div_s[LAST])))
		else $error("divider remainder not below divisor");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] |-> (div_s[0] != '0))
		else $error("zero divisor entered the divider");

	a_head_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] && !rdy[1] |=> vld_s[0] && $stable(rem_s[0][0]) && $stable(div_s[0]))
		else $error("blocked divider stage lost its item");

	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s[LAST] |-> in_ready)
		else $error("divider stalls its input with an empty result stage");

endmodule

`default_nettype wire

@@ hdl/feather_blend_overlap.sv @@
//------------------------------------------------------------------------------
// feather_blend_overlap
// Linear feathering blend of two aligned BGR images across a column overlap.
//
//   channel   direction  handshake               payload
//   pixel     in         pixel_valid/pixel_stall feb_pkg::pixel_t (column, 2 x BGR)
//   blend     out        blend_valid/blend_stall feb_pkg::blend_t (BGR)
//   config    in         wr_en                   wr_index, wr_data
//
// One pixel per clock sustained while blend_stall is low; a pixel transfer
// passes three weighting stages and four divider stages, the last of which
// is the result register, before its result is offered.
// arst_n clears all valid bits and loads the overlap bounds 470 and 630.
// Each stage advances when it is empty or its successor advances, so
// bubbles close up under a stalled output and pixel_stall rises only once
// every stage holds an item.
//------------------------------------------------------------------------------
`default_nettype none

module feather_blend_overlap (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [feb_pkg::CFG_IDX_W-1:0]     wr_index,
	input  wire logic [feb_pkg::CFG_DATA_W-1:0]    wr_data,
	input  wire logic                              pixel_valid,
	output logic                                   pixel_stall,
	input  wire feb_pkg::pixel_t                   pixel,
	output logic                                   blend_valid,
	input  wire logic                              blend_stall,
	output feb_pkg::blend_t                        blend
);
	import feb_pkg::*;

	logic [START_W-1:0] start_q;
	logic [END_W-1:0]   end_q;
	cfg_t               cfg;

	logic               wgt_ready;
	logic               acc_valid;
	logic               acc_ready;
	div_in_t            acc;

	// overlap bounds; writes drop bits above each register's width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_RESET;
			end_q   <= END_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_OVERLAP_START: start_q <= wr_data[START_W-1:0];
				REG_OVERLAP_END:   end_q   <= wr_data[END_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.overlap_start = start_q;
	assign cfg.overlap_end   = end_q;

	// region decode, per-channel weighting and dividend sum
	feb_weight u_weight (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (pixel_valid),
		.in_ready  (wgt_ready),
		.in_data   (pixel),
		.out_valid (acc_valid),
		.out_ready (acc_ready),
		.out_data  (acc)
	);

	// divide by the overlap width, or by one outside the overlap, two quotient bits per stage
	feb_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (acc_valid),
		.in_ready  (acc_ready),
		.in_data   (acc),
		.out_valid (blend_valid),
		.out_ready (!blend_stall),
		.out_data  (blend)
	);

	// hold the pixel side only while the first weighting stage is blocked
	assign pixel_stall = !wgt_ready;

endmodule

`default_nettype wire
